// ----- rtl/server_pool_countdown_allocator_unit_assert.svh -----
// Assertion macros for the server pool countdown allocator.
`ifndef SERVER_POOL_COUNTDOWN_ALLOCATOR_UNIT_ASSERT_SVH
`define SERVER_POOL_COUNTDOWN_ALLOCATOR_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define SPCA_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define SPCA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/spca_pkg.sv -----
// Package: types, codes and constants of the server pool countdown allocator.
package spca_pkg;

	localparam int NUM_SERVERS_DEF = 8;
	localparam int MAX_RESULTS     = 8;
	localparam int RES_CNT_W       = 4;

	typedef enum logic [1:0] {
		KIND_ASSIGNED  = 2'd0,
		KIND_FULL      = 2'd1,
		KIND_DEPART    = 2'd2,
		KIND_IDLE_TICK = 2'd3
	} kind_t;

	typedef enum logic {
		OP_ASSIGN = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ASSIGN_SCAN,
		ST_TICK_SWEEP,
		ST_DEP_SCAN,
		ST_DEP_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] customer_number;
		logic [15:0] arrival_time;
		logic [15:0] waiting_time;
		logic [15:0] service_time;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  server_index;
		logic [15:0] departed_customer;
		logic [17:0] departure_time;
		logic [3:0]  busy_count;
		logic        last;
	} result_t;

	// countdown unit result
	typedef struct packed {
		logic [15:0] next_ticks;
		logic        expired;
	} cd_t;

endpackage

// ----- rtl/spca_ram.sv -----
// Simple dual-port RAM with registered read, one write and one read port.
module spca_ram #(
	parameter int DEPTH = spca_pkg::NUM_SERVERS_DEF,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/spca_countdown.sv -----
// Shared countdown unit: decrements one server's remaining ticks and flags expiry.
module spca_countdown (
	input  logic          busy,
	input  logic [15:0]   ticks,
	output spca_pkg::cd_t cd
);

	always_comb begin
		cd.next_ticks = (ticks != 16'd0) ? (ticks - 16'd1) : 16'd0;
		cd.expired    = busy && (cd.next_ticks == 16'd0);
	end

endmodule

// ----- rtl/server_pool_countdown_allocator_unit.sv -----
// Top level of the server pool countdown allocator: sequencer, server state and result register.
//
// The block keeps NUM_SERVERS servers. An assign item scans the busy flags one server per
// cycle from server 0 and places the customer on the first free one, giving a single result.
// A tick item sweeps all servers through one shared countdown unit, one server per cycle
// behind a registered RAM read, then walks the freed flags and reads each departing customer
// from RAM; at most eight departures are reported, later freed servers are released
// silently. item_ready is high only between items; a finished result sits in the output
// register and does not hold up the next item.
module server_pool_countdown_allocator_unit #(
	parameter int NUM_SERVERS = spca_pkg::NUM_SERVERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  spca_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output spca_pkg::result_t result
);

	localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int CNT_W = $clog2(NUM_SERVERS + 1);
	localparam int RC_W  = spca_pkg::RES_CNT_W;

	spca_pkg::state_t  state_q, state_d;
	logic [15:0]       cust_q;
	logic [15:0]       svc_q;
	logic [17:0]       fin_q;
	logic [CNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx;
	logic              at_end;
	logic [NUM_SERVERS-1:0] busy_q, freed_q;
	logic [CNT_W-1:0]  busy_cnt_q, nf_q;
	logic              p_vld_s1;
	logic [IDX_W-1:0]  p_idx_s1;
	logic [IDX_W-1:0]  dep_idx_q;
	logic [RC_W-1:0]   emit_cnt_q, rep_total_q, rep_total;
	spca_pkg::result_t pend_q, out_q;
	logic              out_vld_q;

	// control decode
	logic accept, assign_hit, assign_full, sweep_issue, sweep_done, tick_upd;
	logic dep_hit, emit_load;

	logic [15:0]      rem_rdata, rem_wdata;
	logic [IDX_W-1:0] rem_waddr;
	logic [33:0]      cf_rdata;
	spca_pkg::cd_t    cd;

	logic [CNT_W+RC_W-1:0] nf_w;
	logic [IDX_W+2:0]      aidx_w, didx_w;
	logic [CNT_W+3:0]      bcnt_w, bcnt_inc_w;
	logic [CNT_W-1:0]      busy_cnt_inc;

	assign idx    = idx_q[IDX_W-1:0];
	assign at_end = (idx_q == CNT_W'(NUM_SERVERS));

	assign nf_w      = {{RC_W{1'b0}}, nf_q};
	assign rep_total = (nf_w > (CNT_W + RC_W)'(spca_pkg::MAX_RESULTS)) ?
		RC_W'(spca_pkg::MAX_RESULTS) : nf_w[RC_W-1:0];

	assign busy_cnt_inc = busy_cnt_q + CNT_W'(1);
	assign aidx_w       = {3'b000, idx};
	assign didx_w       = {3'b000, dep_idx_q};
	assign bcnt_w       = {4'b0000, busy_cnt_q};
	assign bcnt_inc_w   = {4'b0000, busy_cnt_inc};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spca_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = (item.operation == spca_pkg::OP_TICK) ?
						spca_pkg::ST_TICK_SWEEP : spca_pkg::ST_ASSIGN_SCAN;
				end
			end
			spca_pkg::ST_ASSIGN_SCAN: begin
				if (assign_hit || assign_full) begin
					state_d = spca_pkg::ST_EMIT;
				end
			end
			spca_pkg::ST_TICK_SWEEP: begin
				if (sweep_done) begin
					state_d = (nf_q == '0) ? spca_pkg::ST_EMIT : spca_pkg::ST_DEP_SCAN;
				end
			end
			spca_pkg::ST_DEP_SCAN: begin
				if (dep_hit) begin
					state_d = spca_pkg::ST_DEP_READ;
				end
			end
			spca_pkg::ST_DEP_READ: begin
				state_d = spca_pkg::ST_EMIT;
			end
			spca_pkg::ST_EMIT: begin
				if (emit_load) begin
					state_d = (pend_q.kind == spca_pkg::KIND_DEPART && !pend_q.last) ?
						spca_pkg::ST_DEP_SCAN : spca_pkg::ST_IDLE;
				end
			end
			default: state_d = spca_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item_ready  = (state_q == spca_pkg::ST_IDLE);
		accept      = item_ready && item_valid;
		assign_full = (state_q == spca_pkg::ST_ASSIGN_SCAN) && at_end;
		assign_hit  = (state_q == spca_pkg::ST_ASSIGN_SCAN) && !at_end && !busy_q[idx];
		sweep_issue = (state_q == spca_pkg::ST_TICK_SWEEP) && !at_end;
		sweep_done  = (state_q == spca_pkg::ST_TICK_SWEEP) && at_end && !p_vld_s1;
		tick_upd    = (state_q == spca_pkg::ST_TICK_SWEEP) && p_vld_s1 && busy_q[p_idx_s1];
		dep_hit     = (state_q == spca_pkg::ST_DEP_SCAN) && !at_end && freed_q[idx];
		emit_load   = (state_q == spca_pkg::ST_EMIT) && (!out_vld_q || result_ready);
	end

	spca_countdown u_cd (
		.busy  (busy_q[p_idx_s1]),
		.ticks (rem_rdata),
		.cd    (cd)
	);

	assign rem_waddr = assign_hit ? idx : p_idx_s1;
	assign rem_wdata = assign_hit ? svc_q : cd.next_ticks;

	spca_ram #(.DEPTH(NUM_SERVERS), .WIDTH(16), .AW(IDX_W)) u_rem_ram (
		.clk   (clk),
		.we    (assign_hit || tick_upd),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.raddr (idx),
		.rdata (rem_rdata)
	);

	// customer number and departure time per server
	spca_ram #(.DEPTH(NUM_SERVERS), .WIDTH(34), .AW(IDX_W)) u_cf_ram (
		.clk   (clk),
		.we    (assign_hit),
		.waddr (idx),
		.wdata ({cust_q, fin_q}),
		.raddr (idx),
		.rdata (cf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spca_pkg::ST_IDLE;
			busy_q      <= '0;
			freed_q     <= '0;
			busy_cnt_q  <= '0;
			nf_q        <= '0;
			idx_q       <= '0;
			p_vld_s1    <= 1'b0;
			emit_cnt_q  <= '0;
			rep_total_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q    <= '0;
				p_vld_s1 <= 1'b0;
				if (item.operation == spca_pkg::OP_TICK) begin
					freed_q <= '0;
					nf_q    <= '0;
				end
			end
			if ((state_q == spca_pkg::ST_ASSIGN_SCAN) && !assign_hit && !at_end) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (assign_hit) begin
				busy_q[idx] <= 1'b1;
				busy_cnt_q  <= busy_cnt_inc;
			end
			if (state_q == spca_pkg::ST_TICK_SWEEP) begin
				p_vld_s1 <= sweep_issue;
				if (sweep_issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			if (tick_upd && cd.expired) begin
				busy_q[p_idx_s1]  <= 1'b0;
				freed_q[p_idx_s1] <= 1'b1;
				busy_cnt_q        <= busy_cnt_q - CNT_W'(1);
				nf_q              <= nf_q + CNT_W'(1);
			end
			if (sweep_done) begin
				idx_q       <= '0;
				emit_cnt_q  <= '0;
				rep_total_q <= rep_total;
			end
			if ((state_q == spca_pkg::ST_DEP_SCAN) && !at_end) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (state_q == spca_pkg::ST_DEP_READ) begin
				emit_cnt_q <= emit_cnt_q + RC_W'(1);
			end
			if (emit_load) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cust_q <= item.customer_number;
			svc_q  <= (item.service_time == 16'd0) ? 16'd1 : item.service_time;
			fin_q  <= 18'(item.arrival_time) + 18'(item.waiting_time) +
				((item.service_time == 16'd0) ? 18'd1 : 18'(item.service_time));
		end
		if (sweep_issue) begin
			p_idx_s1 <= idx;
		end
		if (dep_hit) begin
			dep_idx_q <= idx;
		end
		if (assign_hit) begin
			pend_q.kind              <= spca_pkg::KIND_ASSIGNED;
			pend_q.server_index      <= aidx_w[2:0];
			pend_q.departed_customer <= 16'd0;
			pend_q.departure_time    <= 18'd0;
			pend_q.busy_count        <= bcnt_inc_w[3:0];
			pend_q.last              <= 1'b1;
		end else if (assign_full) begin
			pend_q.kind              <= spca_pkg::KIND_FULL;
			pend_q.server_index      <= 3'd0;
			pend_q.departed_customer <= 16'd0;
			pend_q.departure_time    <= 18'd0;
			pend_q.busy_count        <= bcnt_w[3:0];
			pend_q.last              <= 1'b1;
		end else if (sweep_done) begin
			pend_q.kind              <= spca_pkg::KIND_IDLE_TICK;
			pend_q.server_index      <= 3'd0;
			pend_q.departed_customer <= 16'd0;
			pend_q.departure_time    <= 18'd0;
			pend_q.busy_count        <= bcnt_w[3:0];
			pend_q.last              <= 1'b1;
		end else if (state_q == spca_pkg::ST_DEP_READ) begin
			pend_q.kind              <= spca_pkg::KIND_DEPART;
			pend_q.server_index      <= didx_w[2:0];
			pend_q.departed_customer <= cf_rdata[33:18];
			pend_q.departure_time    <= cf_rdata[17:0];
			pend_q.busy_count        <= bcnt_w[3:0];
			pend_q.last              <= ((emit_cnt_q + RC_W'(1)) == rep_total_q);
		end
		if (emit_load) begin
			out_q <= pend_q;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

`include "server_pool_countdown_allocator_unit_assert.svh"

	`SPCA_ASSERT_ALWAYS(a_busy_count, busy_cnt_q == CNT_W'($countones(busy_q)), "busy count mismatch")
	`SPCA_ASSERT_ALWAYS(a_busy_bound, busy_cnt_q <= CNT_W'(NUM_SERVERS), "busy count overflow")
	`SPCA_ASSERT_IMPL(a_dep_freed, state_q == spca_pkg::ST_DEP_READ, freed_q[dep_idx_q], "departure from server not freed")
	`SPCA_ASSERT_IMPL(a_last_flag, state_q == spca_pkg::ST_EMIT && pend_q.kind == spca_pkg::KIND_DEPART, pend_q.last == (emit_cnt_q == rep_total_q), "last flag out of step")

endmodule
